### rtl/core/ks_pkg.sv
// Package for the exhaustive knapsack subset search.
// Holds the controller state type, the command and status structs and the fixed field widths.
// Used by ks_ctrl, ks_dp and knapsack_subset_search_top.
package ks_pkg;

  localparam int ItemW    = 16;  // weight and profit of one item
  localparam int CapW     = 20;  // capacity register
  localparam int OutSumW  = 20;  // best_profit and best_weight fields
  localparam int OutMaskW = 16;  // best_mask field

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_SEARCH,
    ST_DONE
  } ks_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;     // store the incoming item
    logic prep;     // clear sums and best, prefetch first delta
    logic search;   // evaluate current subset and step to the next
    logic publish;  // move best into the output register, close the set
  } ks_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last_subset;  // current subset is the final one of the walk
    logic out_blocked;  // output register holds a result not yet taken
  } ks_status_t;

endpackage

### rtl/core/knapsack_subset_search_top.sv
// Exhaustive 0-1 knapsack search, top level; instantiates ks_ctrl and ks_dp and uses ks_pkg.
// Items load one request per cycle, while idle, into a store of MAX_ITEMS entries (extra items are dropped);
// the request marked last starts a walk over all 2^n subsets of the n loaded items, one subset
// per clock; the result then goes into the output register once any earlier result is taken.
// The walk order is a Gray code, so each step adds or subtracts a single item from the running
// weight and profit sums. Ties keep the lowest subset mask value. The input stalls during the
// search; the capacity register has its own valid/ready port, which is always ready; the user
// is to write it only while the block is idle, and the block itself does not enforce this.
module knapsack_subset_search_top
  import ks_pkg::*;
#(
  parameter int MAX_ITEMS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CapW-1:0]     capacity,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [ItemW-1:0]    item_weight,
  input  logic [ItemW-1:0]    item_profit,
  input  logic                item_last,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [OutSumW-1:0]  best_profit,
  output logic [OutSumW-1:0]  best_weight,
  output logic [OutMaskW-1:0] best_mask
);

  ks_cmd_t    cmd;
  ks_status_t status;

  assign cfg_ready = 1'b1;

  ks_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .item_last (item_last),
    .status    (status),
    .cmd       (cmd),
    .in_stall  (in_stall)
  );

  ks_dp #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .item_weight (item_weight),
    .item_profit (item_profit),
    .cfg_write   (cfg_valid & cfg_ready),
    .capacity    (capacity),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .best_profit (best_profit),
    .best_weight (best_weight),
    .best_mask   (best_mask)
  );

endmodule

### rtl/core/ks_ctrl.sv
// Controller state machine for the knapsack subset search.
// Sequences load, prepare, search and publish; depends on ks_pkg.
module ks_ctrl
  import ks_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       item_last,
  input  ks_status_t status,
  output ks_cmd_t    cmd,
  output logic       in_stall
);

  ks_state_t state;
  ks_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    cmd         = '0;
    in_stall    = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (item_last) begin
            state_next = ST_PREP;
          end
        end
      end
      ST_PREP: begin
        cmd.prep   = 1'b1;
        state_next = ST_SEARCH;
      end
      ST_SEARCH: begin
        cmd.search = 1'b1;
        if (status.last_subset) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        // hold until the previous result has been taken
        if (!status.out_blocked) begin
          cmd.publish = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/core/ks_dp.sv
// Datapath for the knapsack subset search: item stores, Gray-code subset walk,
// running sums, best-so-far tracking and the output register. Depends on ks_pkg.
module ks_dp
  import ks_pkg::*;
#(
  parameter int MAX_ITEMS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  ks_cmd_t             cmd,
  output ks_status_t          status,
  input  logic [ItemW-1:0]    item_weight,
  input  logic [ItemW-1:0]    item_profit,
  input  logic                cfg_write,
  input  logic [CapW-1:0]     capacity,
  input  logic                out_stall,
  output logic                out_valid,
  output logic [OutSumW-1:0]  best_profit,
  output logic [OutSumW-1:0]  best_weight,
  output logic [OutMaskW-1:0] best_mask
);

  localparam int IdxW  = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CntW  = $clog2(MAX_ITEMS + 1);
  localparam int SumW  = ItemW + ((MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 0);
  localparam int CmpW  = (SumW > CapW) ? SumW : CapW;
  localparam int OutW  = (SumW > OutSumW) ? SumW : OutSumW;
  localparam int MOutW = (MAX_ITEMS > OutMaskW) ? MAX_ITEMS : OutMaskW;

  logic [ItemW-1:0]     weight_store [MAX_ITEMS];
  logic [ItemW-1:0]     profit_store [MAX_ITEMS];
  logic [CntW-1:0]      item_count;
  logic [CapW-1:0]      cap_limit;

  logic [MAX_ITEMS-1:0] gray;       // current subset
  logic [MAX_ITEMS-1:0] visit;      // position of current subset in the walk
  logic [MAX_ITEMS-1:0] last_visit; // all ones over the loaded items
  logic [MAX_ITEMS:0]   step;       // walk position whose flip is prefetched next
  logic [IdxW-1:0]      flip_idx;   // item toggled on the next advance
  logic [ItemW-1:0]     delta_w;
  logic [ItemW-1:0]     delta_p;
  logic [SumW-1:0]      wsum;
  logic [SumW-1:0]      psum;
  logic [SumW-1:0]      best_p;
  logic [SumW-1:0]      best_w;
  logic [MAX_ITEMS-1:0] best_m;

  logic [IdxW-1:0]      next_flip;
  logic [MAX_ITEMS-1:0] last_visit_next;
  logic                 fits;
  logic                 better;
  logic                 flip_out;
  logic [OutW-1:0]      best_p_ext;
  logic [OutW-1:0]      best_w_ext;
  logic [MOutW-1:0]     best_m_ext;

  // lowest set bit of step: the item that flips at that point of the Gray walk
  always_comb begin
    next_flip = '0;
    for (int i = MAX_ITEMS - 1; i >= 0; i--) begin
      if (step[i]) begin
        next_flip = IdxW'(i);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_ITEMS; i++) begin
      last_visit_next[i] = (CntW'(i) < item_count);
    end
  end

  assign fits     = CmpW'(wsum) <= CmpW'(cap_limit);
  assign better   = (psum > best_p) || ((psum == best_p) && (gray < best_m));
  assign flip_out = gray[flip_idx];

  assign status.last_subset = (visit == last_visit);
  assign status.out_blocked = out_valid && out_stall;

  // stores: written at the fill position, read one entry a cycle during prep and search
  always_ff @(posedge clk) begin
    if (cmd.load && (item_count < CntW'(MAX_ITEMS))) begin
      weight_store[item_count[IdxW-1:0]] <= item_weight;
      profit_store[item_count[IdxW-1:0]] <= item_profit;
    end
    if (cmd.prep) begin
      delta_w <= weight_store[0];
      delta_p <= profit_store[0];
    end else if (cmd.search) begin
      delta_w <= weight_store[next_flip];
      delta_p <= profit_store[next_flip];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_count <= '0;
      cap_limit  <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_write) begin
        cap_limit <= capacity;
      end
      if (cmd.publish) begin
        item_count <= '0;
      end else if (cmd.load && (item_count < CntW'(MAX_ITEMS))) begin
        item_count <= item_count + CntW'(1);
      end
      if (cmd.publish) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // subset walk in Gray order; ties go to the lower subset mask value
  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      gray       <= '0;
      visit      <= '0;
      last_visit <= last_visit_next;
      step       <= (MAX_ITEMS + 1)'(2);
      flip_idx   <= '0;
      wsum       <= '0;
      psum       <= '0;
      best_p     <= '0;
      best_w     <= '0;
      best_m     <= '0;
    end else if (cmd.search) begin
      if (fits && better) begin
        best_p <= psum;
        best_w <= wsum;
        best_m <= gray;
      end
      gray     <= gray ^ (MAX_ITEMS'(1) << flip_idx);
      visit    <= visit + MAX_ITEMS'(1);
      step     <= step + (MAX_ITEMS + 1)'(1);
      flip_idx <= next_flip;
      if (flip_out) begin
        wsum <= wsum - SumW'(delta_w);
        psum <= psum - SumW'(delta_p);
      end else begin
        wsum <= wsum + SumW'(delta_w);
        psum <= psum + SumW'(delta_p);
      end
    end
  end

  assign best_p_ext = OutW'(best_p);
  assign best_w_ext = OutW'(best_w);
  assign best_m_ext = MOutW'(best_m);

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      best_profit <= best_p_ext[OutSumW-1:0];
      best_weight <= best_w_ext[OutSumW-1:0];
      best_mask   <= best_m_ext[OutMaskW-1:0];
    end
  end

endmodule
